// ===== rtl/core/jrma_pkg.sv =====
// ----------------------------------------------------------------------------
// jrma_pkg: shared constants of the jump-reset moving average
// Threshold register format and the depth of the queue between front and back.
// ----------------------------------------------------------------------------
package jrma_pkg;

  localparam int unsigned THRESH_W = 16;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd150;

  // Words that may sit between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage

// ===== rtl/core/jrma_queue.sv =====
// ----------------------------------------------------------------------------
// jrma_queue: short first-in first-out queue
// Decouples the classifying front from the averaging back.
// ----------------------------------------------------------------------------
module jrma_queue #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o     = (fill_q == CntW'(DEPTH));
  assign empty_o    = (fill_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/jrma_front.sv =====
// ----------------------------------------------------------------------------
// jrma_front: input side of the moving average
// Holds the jump threshold and the previous sample and flags each new word
// whose step from the previous one exceeds the threshold.
// ----------------------------------------------------------------------------
module jrma_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [SAMPLE_BITS-1:0]      in_sample_i,
  output logic                        in_ready_o,
  input  logic                        cfg_we_i,
  input  logic [jrma_pkg::THRESH_W-1:0] cfg_wdata_i,
  output logic                        push_o,
  output logic [SAMPLE_BITS-1:0]      push_sample_o,
  output logic                        push_jump_o,
  input  logic                        queue_full_i
);
  import jrma_pkg::*;

  localparam int unsigned CmpW = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

  logic [THRESH_W-1:0]    thresh_q;
  logic [SAMPLE_BITS-1:0] last_q;
  logic [SAMPLE_BITS-1:0] diff;

  assign in_ready_o    = !queue_full_i;
  assign push_o        = in_valid_i && in_ready_o;
  assign push_sample_o = in_sample_i;

  // The step is taken from the previous accepted sample, jump or not.
  assign diff        = (in_sample_i > last_q) ? (in_sample_i - last_q) : (last_q - in_sample_i);
  assign push_jump_o = (CmpW'(diff) > CmpW'(thresh_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
      last_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      if (push_o) begin
        last_q <= in_sample_i;
      end
    end
  end

endmodule

// ===== rtl/core/jrma_back.sv =====
// ----------------------------------------------------------------------------
// jrma_back: window update and averaging
// Shifts each word into the window, keeps a running sum and the valid count,
// and divides the sum by the count with a reciprocal multiply.
// ----------------------------------------------------------------------------
module jrma_back #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   queue_empty_i,
  input  logic [SAMPLE_BITS-1:0] pop_sample_i,
  input  logic                   pop_jump_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  output logic [SAMPLE_BITS-1:0] out_average_o,
  input  logic                   out_ready_i
);
  localparam int unsigned LogW  = $clog2(WINDOW_LEN);
  localparam int unsigned SumW  = SAMPLE_BITS + LogW;
  localparam int unsigned CntW  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned RecW  = SumW + 1;
  localparam int unsigned ProdW = SumW + RecW;
  localparam int unsigned ShW   = $clog2(LogW + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [SAMPLE_BITS-1:0] win_q [WINDOW_LEN];
  logic [SumW-1:0]        sum_q, sum_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [RecW-1:0]        recip_tab [WINDOW_LEN+1];
  logic [ShW-1:0]         shift_tab [WINDOW_LEN+1];
  logic [ProdW-1:0]       prod_q;
  logic [ProdW-1:0]       quo;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] out_q;
  logic                   out_free;

  // Rounded-up reciprocal of a count, scaled so that the product with any
  // window sum truncates to the exact quotient.
  function automatic longint unsigned recip_of(int unsigned c);
    longint unsigned scale;
    if (c == 0) begin
      return 0;
    end
    scale = 64'(1) << (SumW + $clog2(c));
    return (scale + 64'(c) - 64'(1)) / 64'(c);
  endfunction

  for (genvar c = 0; c <= WINDOW_LEN; c++) begin : g_tab
    assign recip_tab[c] = RecW'(recip_of(c));
    assign shift_tab[c] = ShW'($clog2(c));
  end

  assign out_free      = !out_valid_q || out_ready_i;
  assign pop_o         = (state_q == ST_IDLE) && !queue_empty_i;
  assign out_valid_o   = out_valid_q;
  assign out_average_o = out_q;

  // A jump empties the window, so the new word stands alone.
  always_comb begin
    if (pop_jump_i) begin
      sum_d = SumW'(pop_sample_i);
      cnt_d = CntW'(1);
    end else begin
      sum_d = sum_q - SumW'(win_q[0]) + SumW'(pop_sample_i);
      cnt_d = (cnt_q < CntW'(WINDOW_LEN)) ? cnt_q + 1'b1 : cnt_q;
    end
  end

  assign quo = (prod_q >> SumW) >> shift_tab[cnt_q];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (!queue_empty_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
          win_q[i] <= pop_jump_i ? '0 : win_q[i+1];
        end
        win_q[WINDOW_LEN-1] <= pop_sample_i;
        sum_q <= sum_d;
        cnt_q <= cnt_d;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      prod_q <= ProdW'(sum_q) * ProdW'(recip_tab[cnt_q]);
    end
    if (state_q == ST_OUT && out_free) begin
      out_q <= quo[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/jump_reset_moving_average_top.sv =====
// ----------------------------------------------------------------------------
// jump_reset_moving_average_top: moving average with restart on a step
// An accepted sample passes the queue, the window update, the reciprocal
// multiply and the output register, one sample at a time; a two-word queue
// takes inputs while the output is stalled.
// Reset clears window, count, queue and output; threshold returns to 150.
// ----------------------------------------------------------------------------
module jump_reset_moving_average_top #(
  parameter int unsigned WINDOW_LEN  = 5,
  parameter int unsigned SAMPLE_BITS = 16,
  localparam int unsigned DataW      = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [DataW-1:0]              s_axis_tdata,  // sample_mm
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [DataW-1:0]              m_axis_tdata,  // average_mm
  input  logic                          cfg_we_i,
  input  logic [jrma_pkg::THRESH_W-1:0] cfg_wdata_i    // jump_threshold
);
  import jrma_pkg::*;

  logic                   push, push_jump, queue_full;
  logic [SAMPLE_BITS-1:0] push_sample;
  logic                   pop, queue_empty;
  logic [SAMPLE_BITS:0]   pop_word;
  logic [SAMPLE_BITS-1:0] average;

  jrma_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i   (s_axis_tvalid),
    .in_sample_i  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_ready_o   (s_axis_tready),
    .cfg_we_i,
    .cfg_wdata_i,
    .push_o       (push),
    .push_sample_o(push_sample),
    .push_jump_o  (push_jump),
    .queue_full_i (queue_full)
  );

  jrma_queue #(
    .WIDTH(SAMPLE_BITS + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_data_i({push_jump, push_sample}),
    .full_o     (queue_full),
    .pop_i      (pop),
    .pop_data_o (pop_word),
    .empty_o    (queue_empty)
  );

  jrma_back #(
    .WINDOW_LEN (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .queue_empty_i(queue_empty),
    .pop_sample_i (pop_word[SAMPLE_BITS-1:0]),
    .pop_jump_i   (pop_word[SAMPLE_BITS]),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_average_o(average),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = DataW'(average);

endmodule

// ===== rtl/core/jrma_checker.sv =====
// ----------------------------------------------------------------------------
// jrma_checker: port-level checks of the moving average
// Tracks words in flight and checks output hold, flight bound and input ready.
// ----------------------------------------------------------------------------
module jrma_checker #(
  parameter int unsigned DataW = 16
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [DataW-1:0] m_axis_tdata
);
  import jrma_pkg::*;

  localparam int unsigned MaxFlight = QUEUE_DEPTH + 2;

  logic [7:0] flight_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else begin
      flight_q <= flight_q + 8'(in_acc) - 8'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> flight_q != 8'd0)
    else $error("output word without a pending input word");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> flight_q != 8'd0)
    else $error("input stalled with nothing in flight");

  a_flight_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flight_q <= 8'(MaxFlight))
    else $error("more words in flight than the design can hold");

endmodule

bind jump_reset_moving_average_top jrma_checker #(
  .DataW(DataW)
) u_jrma_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid,
  .s_axis_tready,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata
);
